// ----- hdl/int8_two_layer_mlp_defines.svh -----
// ----------------------------------------------------------------------------
// int8_two_layer_mlp_defines
// Assertion macros shared by the two-layer perceptron RTL.
// ----------------------------------------------------------------------------
`ifndef INT8_TWO_LAYER_MLP_DEFINES_SVH
`define INT8_TWO_LAYER_MLP_DEFINES_SVH

// same-cycle implication
`define I8MLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define I8MLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- hdl/i8mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// i8mlp_pkg
// Field widths, operation codes and shared types of the int8 perceptron.
// ----------------------------------------------------------------------------
package i8mlp_pkg;

   localparam int OP_W   = 2;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 5;
   localparam int VAL_W  = 8;
   localparam int IDX_W  = 3;
   localparam int PROD_W = 16;
   localparam int ACC_W  = 32;

   localparam int DEF_NUM_INPUTS  = 16;
   localparam int DEF_NUM_HIDDEN  = 32;
   localparam int DEF_NUM_OUTPUTS = 8;

   localparam logic [OP_W-1:0] OP_WR_L1 = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_L2 = 2'd1;
   localparam logic [OP_W-1:0] OP_ACT   = 2'd2;

   localparam logic signed [ACC_W-1:0] SAT_HI = 127;
   localparam logic signed [ACC_W-1:0] SAT_LO = -128;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic layer2;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
      logic wr_en;
      logic layer2;
   } mac_stat_type;

endpackage

// ----- hdl/i8mlp_if.sv -----
// ----------------------------------------------------------------------------
// i8mlp_if
// Valid/ready channels of the int8 perceptron: request and response beats.
// ----------------------------------------------------------------------------
interface i8mlp_req_if;
   logic                                valid;
   logic                                ready;
   logic        [i8mlp_pkg::OP_W-1:0]   operation;
   logic        [i8mlp_pkg::ROW_W-1:0]  row_index;
   logic        [i8mlp_pkg::COL_W-1:0]  col_index;
   logic signed [i8mlp_pkg::VAL_W-1:0]  value;
   logic                                last_element;
   logic                                enable;

   modport source (output valid, operation, row_index, col_index, value, last_element,
                   enable, input ready);
   modport sink   (input valid, operation, row_index, col_index, value, last_element,
                   enable, output ready);
endinterface

interface i8mlp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [i8mlp_pkg::IDX_W-1:0]  out_index;
   logic signed [i8mlp_pkg::VAL_W-1:0]  out_value;
   logic                                last_out;

   modport source (output valid, out_index, out_value, last_out, input ready);
   modport sink   (input valid, out_index, out_value, last_out, output ready);
endinterface

// ----- hdl/i8mlp_mac.sv -----
// ----------------------------------------------------------------------------
// i8mlp_mac
// Shared multiply-accumulate: registered 8x8 product, 32-bit accumulator and
// clamp of the finished sum (0..127 for layer 1, -128..127 for layer 2).
// ----------------------------------------------------------------------------
module i8mlp_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  i8mlp_pkg::mac_ctrl_type             ctrl,
   input  logic signed [i8mlp_pkg::VAL_W-1:0]  op_a,
   input  logic signed [i8mlp_pkg::VAL_W-1:0]  op_b,
   output i8mlp_pkg::mac_stat_type             stat,
   output logic signed [i8mlp_pkg::VAL_W-1:0]  result
);

   i8mlp_pkg::mac_ctrl_type                   ctrl2_ff;
   logic signed [i8mlp_pkg::PROD_W-1:0]       prod_in;
   logic signed [i8mlp_pkg::PROD_W-1:0]       prod_ff;
   logic signed [i8mlp_pkg::ACC_W-1:0]        acc_in;
   logic signed [i8mlp_pkg::ACC_W-1:0]        acc_ff;
   logic signed [i8mlp_pkg::ACC_W-1:0]        lo_bound;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else begin
         ctrl2_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      if (ctrl2_ff.first) begin
         acc_in = i8mlp_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + i8mlp_pkg::ACC_W'(prod_ff);
      end
   end

   assign lo_bound = ctrl2_ff.layer2 ? i8mlp_pkg::SAT_LO : '0;

   always_comb begin
      if (acc_in > i8mlp_pkg::SAT_HI) begin
         result = i8mlp_pkg::SAT_HI[i8mlp_pkg::VAL_W-1:0];
      end else if (acc_in < lo_bound) begin
         result = lo_bound[i8mlp_pkg::VAL_W-1:0];
      end else begin
         result = acc_in[i8mlp_pkg::VAL_W-1:0];
      end
   end

   assign stat.busy   = ctrl2_ff.valid;
   assign stat.wr_en  = ctrl2_ff.valid & ctrl2_ff.last;
   assign stat.layer2 = ctrl2_ff.layer2;

endmodule

// ----- hdl/int8_two_layer_mlp.sv -----
// ----------------------------------------------------------------------------
// int8_two_layer_mlp
// Two-layer int8 perceptron with weights, inputs and activations in
// synchronous memories and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes one beat per cycle when idle: layer-1 or layer-2 weight
//   writes (out-of-range indices dropped) and activation elements. Weight
//   writes and plain elements give no response. An element beat with
//   last_element set starts a run. With enable set the MAC walks
//   NUM_INPUTS*NUM_HIDDEN then NUM_HIDDEN*NUM_OUTPUTS products, one per
//   cycle, plus a pipeline drain per layer; with enable clear the stored
//   outputs are replayed. Either way NUM_OUTPUTS beats then leave on
//   rsp_bus. The MAC pipeline and the one read port per memory set the
//   pace of a run.
//   req_bus is held off (ready low) from the start of a run until the final
//   response sits in the output register; a stalled rsp_bus holds the run.
//   Reset (synchronous) idles the block and makes stored outputs read zero;
//   weight and input memories are not cleared.
// ----------------------------------------------------------------------------
`include "int8_two_layer_mlp_defines.svh"

module int8_two_layer_mlp #(
   parameter int NUM_INPUTS  = i8mlp_pkg::DEF_NUM_INPUTS,
   parameter int NUM_HIDDEN  = i8mlp_pkg::DEF_NUM_HIDDEN,
   parameter int NUM_OUTPUTS = i8mlp_pkg::DEF_NUM_OUTPUTS
) (
   input logic         clock,
   input logic         reset,
   i8mlp_req_if.sink   req_bus,
   i8mlp_rsp_if.source rsp_bus
);

   localparam int InW    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int HidW   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
   localparam int OutW   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int InnerW = (InW > HidW) ? InW : HidW;
   localparam int OuterW = (HidW > OutW) ? HidW : OutW;
   localparam int W1D    = NUM_INPUTS * NUM_HIDDEN;
   localparam int W2D    = NUM_HIDDEN * NUM_OUTPUTS;
   localparam int W1AW   = (W1D > 1) ? $clog2(W1D) : 1;
   localparam int W2AW   = (W2D > 1) ? $clog2(W2D) : 1;
   localparam int WAW    = (W1AW > W2AW) ? W1AW : W2AW;
   localparam int VW     = i8mlp_pkg::VAL_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_L1_RUN   = 3'd1;
   localparam logic [2:0] ST_L1_DRAIN = 3'd2;
   localparam logic [2:0] ST_L2_RUN   = 3'd3;
   localparam logic [2:0] ST_L2_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT_RD  = 3'd5;
   localparam logic [2:0] ST_EMIT_LD  = 3'd6;

   logic signed [VW-1:0] in_mem  [NUM_INPUTS];
   logic signed [VW-1:0] w1_mem  [W1D];
   logic signed [VW-1:0] w2_mem  [W2D];
   logic signed [VW-1:0] hid_mem [NUM_HIDDEN];
   logic signed [VW-1:0] out_mem [NUM_OUTPUTS];

   logic signed [VW-1:0] in_rd_ff, w1_rd_ff, w2_rd_ff, hid_rd_ff, out_rd_ff;

   logic [2:0]        state_ff, state_in;
   logic [InnerW-1:0] inner_ff, inner_in;
   logic [OuterW-1:0] outer_ff, outer_in;
   logic [WAW-1:0]    wa_ff, wa_in;
   logic [OutW-1:0]   emit_ff, emit_in;
   logic              evald_ff, evald_in;

   i8mlp_pkg::mac_ctrl_type s1_ff, s1_in;
   logic [OuterW-1:0]       s1_dst_ff, s2_dst_ff;
   i8mlp_pkg::mac_stat_type mac_stat;
   logic signed [VW-1:0]    mac_result;

   logic              rsp_valid_ff;
   logic [i8mlp_pkg::IDX_W-1:0] rsp_index_ff;
   logic signed [VW-1:0]        rsp_value_ff;
   logic              rsp_last_ff;
   logic              rsp_load;

   logic        req_fire;
   logic        w1_ok, w2_ok, in_ok;
   logic [31:0] w1_wa_full, w2_wa_full, in_wa_full;
   logic        run, in_l1, inner_last, outer_last, emit_last;
   logic [WAW-1:0] wa_step;

   // ---- request decode ----
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;

   assign in_ok = 32'(req_bus.row_index) < NUM_INPUTS;
   assign w1_ok = in_ok && (32'(req_bus.col_index) < NUM_HIDDEN);
   assign w2_ok = (32'(req_bus.row_index) < NUM_HIDDEN) &&
                  (32'(req_bus.col_index) < NUM_OUTPUTS);

   assign w1_wa_full = 32'(req_bus.row_index) * 32'(NUM_HIDDEN) + 32'(req_bus.col_index);
   assign w2_wa_full = 32'(req_bus.row_index) * 32'(NUM_OUTPUTS) + 32'(req_bus.col_index);
   assign in_wa_full = 32'(req_bus.row_index);

   // ---- memories ----
   always_ff @(posedge clock) begin
      if (req_fire && req_bus.operation == i8mlp_pkg::OP_WR_L1 && w1_ok) begin
         w1_mem[w1_wa_full[W1AW-1:0]] <= req_bus.value;
      end
      w1_rd_ff <= w1_mem[wa_ff[W1AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_bus.operation == i8mlp_pkg::OP_WR_L2 && w2_ok) begin
         w2_mem[w2_wa_full[W2AW-1:0]] <= req_bus.value;
      end
      w2_rd_ff <= w2_mem[wa_ff[W2AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_bus.operation == i8mlp_pkg::OP_ACT && in_ok) begin
         in_mem[in_wa_full[InW-1:0]] <= req_bus.value;
      end
      in_rd_ff <= in_mem[inner_ff[InW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mac_stat.wr_en && !mac_stat.layer2) begin
         hid_mem[s2_dst_ff[HidW-1:0]] <= mac_result;
      end
      hid_rd_ff <= hid_mem[inner_ff[HidW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mac_stat.wr_en && mac_stat.layer2) begin
         out_mem[s2_dst_ff[OutW-1:0]] <= mac_result;
      end
      out_rd_ff <= out_mem[emit_ff];
   end

   // ---- product issue ----
   assign run   = (state_ff == ST_L1_RUN) || (state_ff == ST_L2_RUN);
   assign in_l1 = (state_ff == ST_L1_RUN);

   assign inner_last = in_l1 ? (inner_ff == InnerW'(NUM_INPUTS - 1))
                             : (inner_ff == InnerW'(NUM_HIDDEN - 1));
   assign outer_last = in_l1 ? (outer_ff == OuterW'(NUM_HIDDEN - 1))
                             : (outer_ff == OuterW'(NUM_OUTPUTS - 1));
   assign wa_step    = in_l1 ? WAW'(NUM_HIDDEN) : WAW'(NUM_OUTPUTS);
   assign emit_last  = (emit_ff == OutW'(NUM_OUTPUTS - 1));

   always_comb begin
      s1_in.valid  = run;
      s1_in.first  = (inner_ff == '0);
      s1_in.last   = inner_last;
      s1_in.layer2 = (state_ff == ST_L2_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dst_ff <= outer_ff;
      s2_dst_ff <= s1_dst_ff;
   end

   i8mlp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (s1_ff),
      .op_a   (s1_ff.layer2 ? hid_rd_ff : in_rd_ff),
      .op_b   (s1_ff.layer2 ? w2_rd_ff : w1_rd_ff),
      .stat   (mac_stat),
      .result (mac_result)
   );

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      wa_in    = wa_ff;
      emit_in  = emit_ff;
      evald_in = evald_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.operation == i8mlp_pkg::OP_ACT &&
                req_bus.last_element) begin
               inner_in = '0;
               outer_in = '0;
               wa_in    = '0;
               emit_in  = '0;
               state_in = req_bus.enable ? ST_L1_RUN : ST_EMIT_RD;
            end
         end
         ST_L1_RUN, ST_L2_RUN: begin
            if (inner_last) begin
               inner_in = '0;
               if (outer_last) begin
                  outer_in = '0;
                  wa_in    = '0;
                  state_in = in_l1 ? ST_L1_DRAIN : ST_L2_DRAIN;
               end else begin
                  outer_in = outer_ff + OuterW'(1);
                  wa_in    = WAW'(outer_ff) + WAW'(1);
               end
            end else begin
               inner_in = inner_ff + InnerW'(1);
               wa_in    = wa_ff + wa_step;
            end
         end
         ST_L1_DRAIN: begin
            if (!s1_ff.valid && !mac_stat.busy) begin
               state_in = ST_L2_RUN;
            end
         end
         ST_L2_DRAIN: begin
            if (!s1_ff.valid && !mac_stat.busy) begin
               evald_in = 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + OutW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inner_ff <= '0;
         outer_ff <= '0;
         wa_ff    <= '0;
         emit_ff  <= '0;
         evald_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
         wa_ff    <= wa_in;
         emit_ff  <= emit_in;
         evald_ff <= evald_in;
      end
   end

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= i8mlp_pkg::IDX_W'(emit_ff);
         rsp_value_ff <= evald_ff ? out_rd_ff : '0;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.last_out  = rsp_last_ff;

   // ---- assertions ----
   `I8MLP_ASSERT_IMPLY(a_hid_wr_in_l1, clock, reset, mac_stat.wr_en && !mac_stat.layer2, state_ff == ST_L1_RUN || state_ff == ST_L1_DRAIN)
   `I8MLP_ASSERT_NEXT(a_eval_start, clock, reset, req_fire && req_bus.operation == i8mlp_pkg::OP_ACT && req_bus.last_element && req_bus.enable, state_ff == ST_L1_RUN)
   `I8MLP_ASSERT_IMPLY(a_issue_from_run, clock, reset, s1_ff.valid, $past(state_ff == ST_L1_RUN || state_ff == ST_L2_RUN))

endmodule

// ----- tb/i8mlp_run_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8mlp_run_checker
// Watches the request and response channels of the int8 perceptron and keeps
// its own copy of the weights, inputs and stored activations. For every
// accepted request beat it works out the output run that the beat causes and
// queues it. Each response beat is then compared field by field, in order,
// with the oldest queued output.
// ----------------------------------------------------------------------------
module i8mlp_run_checker (
   input  logic clock,
   input  logic reset,
   i8mlp_req_if req_mon,
   i8mlp_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   reqs_seen,
   output int   beats_checked
);

   localparam int N_IN  = i8mlp_pkg::DEF_NUM_INPUTS;
   localparam int N_HID = i8mlp_pkg::DEF_NUM_HIDDEN;
   localparam int N_OUT = i8mlp_pkg::DEF_NUM_OUTPUTS;

   typedef struct packed {
      logic [i8mlp_pkg::IDX_W-1:0]        index;
      logic signed [i8mlp_pkg::VAL_W-1:0] value;
      logic                               last;
   } out_beat_type;

   logic signed [i8mlp_pkg::VAL_W-1:0] act_vec [N_IN];
   logic signed [i8mlp_pkg::VAL_W-1:0] w1      [N_IN][N_HID];
   logic signed [i8mlp_pkg::VAL_W-1:0] w2      [N_HID][N_OUT];
   logic signed [i8mlp_pkg::VAL_W-1:0] hidden  [N_HID];
   logic signed [i8mlp_pkg::VAL_W-1:0] out_act [N_OUT];
   out_beat_type                       expected_outputs [$];

   int fails   = 0;
   int checked = 0;
   int seen    = 0;

   // hidden units clamp to 0..127, outputs saturate to -128..127
   function automatic void run_network();
      logic signed [i8mlp_pkg::ACC_W-1:0] acc;
      for (int h = 0; h < N_HID; h++) begin
         acc = '0;
         for (int i = 0; i < N_IN; i++)
            acc += int'(act_vec[i]) * int'(w1[i][h]);
         if (acc < 0)
            hidden[h] = '0;
         else if (acc > i8mlp_pkg::SAT_HI)
            hidden[h] = i8mlp_pkg::SAT_HI[i8mlp_pkg::VAL_W-1:0];
         else
            hidden[h] = acc[i8mlp_pkg::VAL_W-1:0];
      end
      for (int o = 0; o < N_OUT; o++) begin
         acc = '0;
         for (int h = 0; h < N_HID; h++)
            acc += int'(hidden[h]) * int'(w2[h][o]);
         if (acc < i8mlp_pkg::SAT_LO)
            out_act[o] = i8mlp_pkg::SAT_LO[i8mlp_pkg::VAL_W-1:0];
         else if (acc > i8mlp_pkg::SAT_HI)
            out_act[o] = i8mlp_pkg::SAT_HI[i8mlp_pkg::VAL_W-1:0];
         else
            out_act[o] = acc[i8mlp_pkg::VAL_W-1:0];
      end
   endfunction

   function automatic void apply_request(input logic [i8mlp_pkg::OP_W-1:0] op,
                                         input logic [i8mlp_pkg::ROW_W-1:0] row,
                                         input logic [i8mlp_pkg::COL_W-1:0] col,
                                         input logic signed [i8mlp_pkg::VAL_W-1:0] val,
                                         input logic last, input logic en);
      out_beat_type beat;
      case (op)
         i8mlp_pkg::OP_WR_L1: begin
            if (row < N_IN && col < N_HID) w1[row][col] = val;
         end
         i8mlp_pkg::OP_WR_L2: begin
            if (row < N_HID && col < N_OUT) w2[row][col] = val;
         end
         i8mlp_pkg::OP_ACT: begin
            if (row < N_IN) act_vec[row] = val;
            if (last) begin
               if (en) run_network();
               for (int o = 0; o < N_OUT; o++) begin
                  beat.index = i8mlp_pkg::IDX_W'(o);
                  beat.value = out_act[o];
                  beat.last  = (o == N_OUT - 1);
                  expected_outputs.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         foreach (hidden[h]) hidden[h] = '0;
         foreach (out_act[o]) out_act[o] = '0;
         expected_outputs.delete();
         fails   = 0;
         checked = 0;
         seen    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (expected_outputs.size() == 0) begin
               fails++;
               $display("%0t: unexpected output beat: index %0d value %0d last %0b",
                        $time, rsp_mon.out_index, rsp_mon.out_value, rsp_mon.last_out);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_mon.out_index !== want.index || rsp_mon.out_value !== want.value ||
                   rsp_mon.last_out !== want.last) begin
                  fails++;
                  $display({"%0t: output beat mismatch: expected index %0d value %0d ",
                            "last %0b, got index %0d value %0d last %0b"},
                           $time, want.index, $signed(want.value), want.last,
                           rsp_mon.out_index, rsp_mon.out_value, rsp_mon.last_out);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seen++;
            apply_request(req_mon.operation, req_mon.row_index, req_mon.col_index,
                          req_mon.value, req_mon.last_element, req_mon.enable);
         end
      end
      fail_count    <= fails;
      pending       <= expected_outputs.size();
      reqs_seen     <= seen;
      beats_checked <= checked;
   end

endmodule

// ----- tb/tb_int8_two_layer_mlp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_two_layer_mlp
// Stimulus and verdict for the int8 two-layer perceptron. After a few
// directed beats that touch the ignored and replay cases, every weight and
// input is written, then random vectors, weight bursts and noise are driven
// under changing idle patterns on both channels. Checking is done by the
// run checker beside the block.
// ----------------------------------------------------------------------------
module tb_int8_two_layer_mlp;
   import i8mlp_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   localparam int N_IN          = DEF_NUM_INPUTS;
   localparam int N_HID         = DEF_NUM_HIDDEN;
   localparam int N_OUT         = DEF_NUM_OUTPUTS;
   localparam int RANDOM_ITEMS  = 460;
   localparam int LONG_HOLD     = 1200;
   localparam int QUIET_LIMIT   = 8000;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   i8mlp_req_if req_bus ();
   i8mlp_rsp_if rsp_bus ();

   int fail_count;
   int pending;
   int reqs_seen;
   int beats_checked;

   int n_sent        = 0;
   int n_ignored     = 0;
   int n_runs        = 0;
   int send_idle_pct = 20;
   int recv_idle_pct = 50;
   bit want_hold     = 1'b0;

   int8_two_layer_mlp dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   i8mlp_run_checker run_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .reqs_seen     (reqs_seen),
      .beats_checked (beats_checked)
   );

   // small values keep the sums inside the clamp range often enough
   function automatic logic signed [VAL_W-1:0] pick_value(input bit wide);
      int r;
      r = $urandom_range(9);
      if (!wide) return VAL_W'(int'($urandom_range(6)) - 3);
      if (r == 0) return SAT_HI[VAL_W-1:0];
      if (r == 1) return SAT_LO[VAL_W-1:0];
      return VAL_W'($urandom_range(255));
   endfunction

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col,
                            input logic signed [VAL_W-1:0] val,
                            input logic last, input logic en);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.row_index    <= row;
      req_bus.col_index    <= col;
      req_bus.value        <= val;
      req_bus.last_element <= last;
      req_bus.enable       <= en;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      n_sent++;
      if (op == OP_RESERVED || (op == OP_WR_L1 && (row >= N_IN || col >= N_HID)) ||
          (op == OP_WR_L2 && (row >= N_HID || col >= N_OUT)))
         n_ignored++;
      if (op == OP_ACT && last) n_runs++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (reqs_seen != n_sent || pending != 0);
   endtask

   // receiver
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat on either channel for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int  counted;
      int  kind;
      int  n;
      int  phase;
      bit  wide;

      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_WR_L1;
      req_bus.row_index    <= '0;
      req_bus.col_index    <= '0;
      req_bus.value        <= '0;
      req_bus.last_element <= 1'b0;
      req_bus.enable       <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stored outputs are zero after reset: replay without evaluation
      send_beat(OP_ACT, '0, '0, SAT_LO[VAL_W-1:0], 1'b1, 1'b0);
      send_beat(OP_ACT, '1, '1, SAT_HI[VAL_W-1:0], 1'b1, 1'b0);
      send_beat(OP_RESERVED, '1, '1, '1, 1'b1, 1'b1);
      send_beat(OP_WR_L1, '1, '1, SAT_HI[VAL_W-1:0], 1'b1, 1'b1);
      send_beat(OP_WR_L2, '1, '1, SAT_LO[VAL_W-1:0], 1'b0, 1'b0);
      send_beat(OP_WR_L2, '0, COL_W'(N_OUT), 8'h55, 1'b0, 1'b1);
      send_beat(OP_WR_L1, ROW_W'(N_IN - 1), '1, 8'hAA, 1'b1, 1'b1);
      send_beat(OP_ACT, ROW_W'(5), '0, SAT_HI[VAL_W-1:0], 1'b0, 1'b1);

      // write every weight and input before the first evaluation
      for (int i = 0; i < N_IN; i++)
         for (int h = 0; h < N_HID; h++)
            send_beat(OP_WR_L1, ROW_W'(i), COL_W'(h), pick_value($urandom_range(4) == 0),
                      1'b0, 1'b0);
      for (int h = 0; h < N_HID; h++)
         for (int o = 0; o < N_OUT; o++)
            send_beat(OP_WR_L2, ROW_W'(h), COL_W'(o), pick_value($urandom_range(4) == 0),
                      1'b0, 1'b0);
      for (int i = 0; i < N_IN; i++)
         send_beat(OP_ACT, ROW_W'(i), '0, pick_value(1'b0), i == N_IN - 1, 1'b1);

      send_beat(OP_ACT, ROW_W'(N_IN), '0, '0, 1'b1, 1'b1);
      send_beat(OP_ACT, ROW_W'(N_IN - 1), '0, SAT_HI[VAL_W-1:0], 1'b1, 1'b1);
      send_beat(OP_ACT, '0, '0, SAT_LO[VAL_W-1:0], 1'b1, 1'b0);
      send_beat(OP_ACT, '0, '0, SAT_LO[VAL_W-1:0], 1'b1, 1'b1);

      // long output stall while a full vector and more beats are offered
      want_hold = 1'b1;
      for (int i = 0; i < N_IN; i++)
         send_beat(OP_ACT, ROW_W'(i), COL_W'($urandom_range(31)), pick_value(1'b1),
                   i == N_IN - 1, 1'b1);
      counted = N_IN;
      phase   = 0;

      while (counted < RANDOM_ITEMS) begin
         if (phase == 0 && counted >= RANDOM_ITEMS / 3) begin
            phase = 1;
            wait_idle();
            send_idle_pct = 50;
            recv_idle_pct = 20;
            want_hold     = 1'b1;
         end else if (phase == 1 && counted >= 2 * RANDOM_ITEMS / 3) begin
            phase = 2;
            wait_idle();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         kind = $urandom_range(99);
         wide = ($urandom_range(2) == 0);
         if (kind < 55) begin
            n = ($urandom_range(6) != 0);
            for (int i = 0; i < N_IN; i++)
               send_beat(OP_ACT, ROW_W'(i), COL_W'($urandom_range(31)), pick_value(wide),
                         i == N_IN - 1, (i == N_IN - 1) ? 1'(n) : 1'($urandom_range(1)));
            counted += N_IN;
         end else if (kind < 80) begin
            n = $urandom_range(8, 1);
            repeat (n) begin
               if ($urandom_range(1))
                  send_beat(OP_WR_L2, ROW_W'($urandom_range(N_HID - 1)),
                            COL_W'($urandom_range(N_OUT - 1)), pick_value(wide),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
               else
                  send_beat(OP_WR_L1, ROW_W'($urandom_range(N_IN - 1)),
                            COL_W'($urandom_range(N_HID - 1)), pick_value(wide),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            counted += n;
         end else if (kind < 90) begin
            send_beat(OP_ACT, ROW_W'($urandom_range(N_IN - 1)), COL_W'($urandom_range(31)),
                      pick_value(wide), 1'($urandom_range(1)), 1'($urandom_range(1)));
            counted++;
         end else begin
            case ($urandom_range(3))
               0: send_beat(OP_RESERVED, ROW_W'($urandom_range(31)),
                            COL_W'($urandom_range(31)), pick_value(1'b1),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
               1: send_beat(OP_WR_L1, ROW_W'($urandom_range(31, N_IN)),
                            COL_W'($urandom_range(31)), pick_value(1'b1),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
               2: send_beat(OP_WR_L2, ROW_W'($urandom_range(31)),
                            COL_W'($urandom_range(31, N_OUT)), pick_value(1'b1),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
               default: begin
                  send_beat(OP_ACT, ROW_W'($urandom_range(31, N_IN)),
                            COL_W'($urandom_range(31)), pick_value(1'b1), 1'b1,
                            1'($urandom_range(1)));
                  counted++;
               end
            endcase
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d request beats (%0d dropped by the block), %0d output runs, %0d output beats checked",
               n_sent, n_ignored, n_runs, beats_checked);
      $display("All %0d weights preloaded; three idle mixes, two long output stalls, drain pauses",
               N_IN * N_HID + N_HID * N_OUT);
      if (fail_count == 0 && pending == 0 && reqs_seen == n_sent)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
